// File: rtl/ray_triangle_intersect_macros.svh
// ----------------------------------------------------------------------------
// ray_triangle_intersect_macros
// Assertion macros for the ray triangle intersection block.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define RTI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define RTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants for the ray triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;
  localparam int CoordW = 32;
  localparam int EdgeW = 33;
  localparam int CrossW = 67;
  localparam int DotW = 102;
  localparam int DivW = 128;
  localparam logic [2:0] RegOriginX = 3'd0;
  localparam logic [2:0] RegOriginY = 3'd1;
  localparam logic [2:0] RegOriginZ = 3'd2;
  localparam logic [2:0] RegDirX = 3'd3;
  localparam logic [2:0] RegDirY = 3'd4;
  localparam logic [2:0] RegDirZ = 3'd5;
  localparam logic [2:0] RegEps = 3'd6;
endpackage

// File: rtl/rti_divider.sv
// ----------------------------------------------------------------------------
// rti_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rti_divider
  import rti_pkg::*;
#(
  parameter int QBITS = 31
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [DivW-1:0]           in_num,
  input  logic [DotW-1:0]           in_den,
  input  logic                      in_side,
  output logic                      out_vld,
  output logic                      out_ovf,
  output logic [QBITS-1:0]          out_quo,
  output logic                      out_side
);
  // The input stage checks whether the quotient reaches 2^QBITS. If it does,
  // out_ovf is set and out_quo carries no meaning; otherwise the upper part
  // of the numerator is already below the divisor and seeds the remainder.
  logic [DivW-1:0]           hi;
  logic                      ovf;
  logic [QBITS:0]            vld_r;
  logic [DotW:0]             rem_r [QBITS+1];
  logic [QBITS-1:0]          num_r [QBITS+1];
  logic [DotW-1:0]           den_r [QBITS+1];
  logic [QBITS-1:0]          quo_r [QBITS+1];
  logic                      ovf_r [QBITS+1];
  logic                      side_r [QBITS+1];

  assign hi  = in_num >> QBITS;
  assign ovf = hi >= DivW'(in_den);

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[QBITS-1:0], in_vld};
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= ovf ? '0 : (DotW+1)'(hi);
    num_r[0]  <= in_num[QBITS-1:0];
    den_r[0]  <= in_den;
    quo_r[0]  <= '0;
    ovf_r[0]  <= ovf;
    side_r[0] <= in_side;
  end

  for (genvar g = 0; g < QBITS; g++) begin : g_stage
    logic [DotW+1:0] sh;
    logic [DotW+1:0] df;
    assign sh = {rem_r[g], num_r[g][QBITS-1-g]};
    assign df = sh - {2'b00, den_r[g]};
    always_ff @(posedge clk) begin
      rem_r[g+1]  <= df[DotW+1] ? sh[DotW:0] : df[DotW:0];
      quo_r[g+1]  <= {quo_r[g][QBITS-2:0], ~df[DotW+1]};
      num_r[g+1]  <= num_r[g];
      den_r[g+1]  <= den_r[g];
      ovf_r[g+1]  <= ovf_r[g];
      side_r[g+1] <= side_r[g];
    end
  end

  assign out_vld  = vld_r[QBITS];
  assign out_ovf  = ovf_r[QBITS];
  assign out_quo  = quo_r[QBITS];
  assign out_side = side_r[QBITS];
endmodule

// File: rtl/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Fixed-point Moller-Trumbore ray against triangle test, fully pipelined.
// ----------------------------------------------------------------------------
// One triangle beat is taken every clock cycle; busy is always low after
// reset. The path has 41 register stages: six arithmetic stages, the
// divider's input stage and its 31 quotient stages (one per quotient bit
// below the 2^31 saturation limit), and three output stages. So out_valid
// is high for one cycle per accepted beat, once the beat has passed every
// stage, whatever the data. The receiver cannot stall, so nothing is ever
// held back. Ray registers must be written through the APB port only while
// no beat is in flight; the block itself does not enforce this.
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_corner0_x,
  input  logic signed [31:0] in_corner0_y,
  input  logic signed [31:0] in_corner0_z,
  input  logic signed [31:0] in_corner1_x,
  input  logic signed [31:0] in_corner1_y,
  input  logic signed [31:0] in_corner1_z,
  input  logic signed [31:0] in_corner2_x,
  input  logic signed [31:0] in_corner2_y,
  input  logic signed [31:0] in_corner2_z,
  output logic               out_valid,
  output logic               out_hit,
  output logic signed [31:0] out_distance,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  // Quotient bits needed below the saturation limit; larger quotients are
  // flagged by the divider and saturate.
  localparam int QBITS = 31;
  // Split of the 67-bit cross product for the dot-product multiplies.
  localparam int SplitW = 34;
  localparam int HiW = CrossW - SplitW;
  localparam int HiPW = EdgeW + HiW;
  localparam int LoPW = EdgeW + SplitW + 1;

  // Configuration registers.
  logic signed [31:0] org_r [3];
  logic signed [31:0] dir_r [3];
  logic [30:0]        eps_r;
  logic               wr_en;
  logic [2:0]         widx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0; org_r[1] <= '0; org_r[2] <= '0;
      dir_r[0] <= '0; dir_r[1] <= '0; dir_r[2] <= 32'sd65536;
      eps_r <= 31'd1;
    end else if (wr_en) begin
      unique case (widx)
        RegOriginX: org_r[0] <= pwdata;
        RegOriginY: org_r[1] <= pwdata;
        RegOriginZ: org_r[2] <= pwdata;
        RegDirX:    dir_r[0] <= pwdata;
        RegDirY:    dir_r[1] <= pwdata;
        RegDirZ:    dir_r[2] <= pwdata;
        RegEps:     eps_r    <= pwdata[30:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      RegOriginX: prdata = org_r[0];
      RegOriginY: prdata = org_r[1];
      RegOriginZ: prdata = org_r[2];
      RegDirX:    prdata = dir_r[0];
      RegDirY:    prdata = dir_r[1];
      RegDirZ:    prdata = dir_r[2];
      RegEps:     prdata = {1'b0, eps_r};
      default:    prdata = '0;
    endcase
  end

  // Stage 1: edges and the origin offset, 33 bits each.
  logic               s1_vld_r;
  logic signed [EdgeW-1:0] e1_r [3], e2_r [3], sv_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else s1_vld_r <= start;
  end
  always_ff @(posedge clk) begin
    e1_r[0] <= EdgeW'(in_corner1_x) - EdgeW'(in_corner0_x);
    e1_r[1] <= EdgeW'(in_corner1_y) - EdgeW'(in_corner0_y);
    e1_r[2] <= EdgeW'(in_corner1_z) - EdgeW'(in_corner0_z);
    e2_r[0] <= EdgeW'(in_corner2_x) - EdgeW'(in_corner0_x);
    e2_r[1] <= EdgeW'(in_corner2_y) - EdgeW'(in_corner0_y);
    e2_r[2] <= EdgeW'(in_corner2_z) - EdgeW'(in_corner0_z);
    sv_r[0] <= EdgeW'(org_r[0]) - EdgeW'(in_corner0_x);
    sv_r[1] <= EdgeW'(org_r[1]) - EdgeW'(in_corner0_y);
    sv_r[2] <= EdgeW'(org_r[2]) - EdgeW'(in_corner0_z);
  end

  // Stage 2: cross-product partial products, one 33x33 multiply each.
  logic s2_vld_r;
  logic signed [65:0] hp_r [6], qp_r [6];
  logic signed [EdgeW-1:0] e1b_r [3], e2b_r [3], svb_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else s2_vld_r <= s1_vld_r;
  end
  always_ff @(posedge clk) begin
    hp_r[0] <= EdgeW'(dir_r[1]) * e2_r[2];
    hp_r[1] <= EdgeW'(dir_r[2]) * e2_r[1];
    hp_r[2] <= EdgeW'(dir_r[2]) * e2_r[0];
    hp_r[3] <= EdgeW'(dir_r[0]) * e2_r[2];
    hp_r[4] <= EdgeW'(dir_r[0]) * e2_r[1];
    hp_r[5] <= EdgeW'(dir_r[1]) * e2_r[0];
    qp_r[0] <= sv_r[1] * e1_r[2];
    qp_r[1] <= sv_r[2] * e1_r[1];
    qp_r[2] <= sv_r[2] * e1_r[0];
    qp_r[3] <= sv_r[0] * e1_r[2];
    qp_r[4] <= sv_r[0] * e1_r[1];
    qp_r[5] <= sv_r[1] * e1_r[0];
    e1b_r <= e1_r; e2b_r <= e2_r; svb_r <= sv_r;
  end

  // Stage 3: cross products h and q.
  logic s3_vld_r;
  logic signed [CrossW-1:0] h_r [3], q_r [3];
  logic signed [EdgeW-1:0] e1c_r [3], e2c_r [3], svc_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else s3_vld_r <= s2_vld_r;
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      h_r[k] <= CrossW'(hp_r[2*k]) - CrossW'(hp_r[2*k+1]);
      q_r[k] <= CrossW'(qp_r[2*k]) - CrossW'(qp_r[2*k+1]);
    end
    e1c_r <= e1b_r; e2c_r <= e2b_r; svc_r <= svb_r;
  end

  // Stage 4: dot-product partial products. Each 67-bit cross product is cut
  // into a signed high part and an unsigned low part of 34 bits, so that no
  // single multiply exceeds about 33x35.
  logic s4_vld_r;
  logic signed [HiW-1:0]   hh [3], qh [3];
  logic signed [SplitW:0]  hl [3], ql [3];
  logic signed [HiPW-1:0]  ah_r [3], uh_r [3], vh_r [3], th_r [3];
  logic signed [LoPW-1:0]  al_r [3], ul_r [3], vl_r [3], tl_r [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hh[k] = h_r[k][CrossW-1:SplitW];
      qh[k] = q_r[k][CrossW-1:SplitW];
      hl[k] = {1'b0, h_r[k][SplitW-1:0]};
      ql[k] = {1'b0, q_r[k][SplitW-1:0]};
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else s4_vld_r <= s3_vld_r;
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ah_r[k] <= HiPW'(e1c_r[k]) * HiPW'(hh[k]);
      al_r[k] <= LoPW'(e1c_r[k]) * LoPW'(hl[k]);
      uh_r[k] <= HiPW'(svc_r[k]) * HiPW'(hh[k]);
      ul_r[k] <= LoPW'(svc_r[k]) * LoPW'(hl[k]);
      vh_r[k] <= HiPW'(dir_r[k]) * HiPW'(qh[k]);
      vl_r[k] <= LoPW'(dir_r[k]) * LoPW'(ql[k]);
      th_r[k] <= HiPW'(e2c_r[k]) * HiPW'(qh[k]);
      tl_r[k] <= LoPW'(e2c_r[k]) * LoPW'(ql[k]);
    end
  end

  // Stage 5: dot sums. The high partials are weighted by 2^34 before the
  // six terms are added.
  function automatic logic signed [DotW-1:0] dot_sum(
    input logic signed [HiPW-1:0] h0, h1, h2,
    input logic signed [LoPW-1:0] l0, l1, l2
  );
    return (DotW'(h0) <<< SplitW) + (DotW'(h1) <<< SplitW) + (DotW'(h2) <<< SplitW)
      + DotW'(l0) + DotW'(l1) + DotW'(l2);
  endfunction

  logic s5_vld_r;
  logic signed [DotW-1:0] a_r, un_r, vn_r, tn_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else s5_vld_r <= s4_vld_r;
  end
  always_ff @(posedge clk) begin
    a_r  <= dot_sum(ah_r[0], ah_r[1], ah_r[2], al_r[0], al_r[1], al_r[2]);
    un_r <= dot_sum(uh_r[0], uh_r[1], uh_r[2], ul_r[0], ul_r[1], ul_r[2]);
    vn_r <= dot_sum(vh_r[0], vh_r[1], vh_r[2], vl_r[0], vl_r[1], vl_r[2]);
    tn_r <= dot_sum(th_r[0], th_r[1], th_r[2], tl_r[0], tl_r[1], tl_r[2]);
  end

  // Stage 6: absolute determinant and inside tests.
  logic s6_vld_r, s6_ok_r;
  logic [DotW-1:0] absa_r, tnf_r;
  logic signed [DotW-1:0] unf, vnf, tnf, absa;
  logic signed [DotW:0] uv;
  logic [DotW-1:0] thr;
  always_comb begin
    absa = a_r[DotW-1] ? -a_r : a_r;
    unf  = a_r[DotW-1] ? -un_r : un_r;
    vnf  = a_r[DotW-1] ? -vn_r : vn_r;
    tnf  = a_r[DotW-1] ? -tn_r : tn_r;
    uv   = (DotW+1)'(unf) + (DotW+1)'(vnf);
    thr  = DotW'(eps_r) << (2*FRAC_BITS);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else s6_vld_r <= s5_vld_r;
  end
  always_ff @(posedge clk) begin
    s6_ok_r <= (a_r != '0) && !(absa < thr) && !unf[DotW-1] && !(unf > absa)
      && !vnf[DotW-1] && !(uv > (DotW+1)'(absa)) && !tnf[DotW-1] && (tnf != '0);
    absa_r <= absa;
    tnf_r  <= tnf;
  end

  // Divider: the quotient is not bounded by the inside tests, since a ray
  // nearly parallel to the plane gives a tiny determinant. Only quotients
  // below 2^31 are computed; the divider flags anything larger, which
  // saturates and always clears the distance threshold.
  logic             dv_vld, dv_ovf;
  logic [QBITS-1:0] dv_quo;
  logic             dv_side;
  rti_divider #(.QBITS(QBITS)) u_div (
    .clk(clk), .rst_n(rst_n), .in_vld(s6_vld_r),
    .in_num(DivW'(tnf_r) << FRAC_BITS), .in_den(absa_r),
    .in_side(s6_ok_r),
    .out_vld(dv_vld), .out_ovf(dv_ovf), .out_quo(dv_quo), .out_side(dv_side)
  );

  // Stage 7: distance test and saturation.
  logic s7_vld_r, s7_hit_r;
  logic signed [31:0] d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s7_vld_r <= 1'b0;
    else s7_vld_r <= dv_vld;
  end
  always_ff @(posedge clk) begin
    s7_hit_r <= dv_side && (dv_ovf || (dv_quo > QBITS'(eps_r)));
    d_r <= dv_ovf ? 32'sh7fffffff : 32'(dv_quo);
  end

  // Stage 8: direction times distance.
  logic s8_vld_r, s8_hit_r;
  logic signed [31:0] d8_r;
  logic signed [63:0] p_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s8_vld_r <= 1'b0;
    else s8_vld_r <= s7_vld_r;
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) p_r[k] <= 64'(dir_r[k]) * 64'(d_r);
    s8_hit_r <= s7_hit_r;
    d8_r <= d_r;
  end

  // Stage 9: add origin with saturation, zero on miss. The shifted product
  // can reach 2^46, so the sum is kept at full width before clamping.
  logic signed [64:0] sum [3];
  logic signed [31:0] pt [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = 65'(org_r[k]) + 65'(p_r[k] >>> FRAC_BITS);
      if (sum[k] > 65'sh0_7fff_ffff) pt[k] = 32'sh7fffffff;
      else if (sum[k] < -65'sh0_8000_0000) pt[k] = 32'sh80000000;
      else pt[k] = sum[k][31:0];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= s8_vld_r;
  end
  always_ff @(posedge clk) begin
    out_hit      <= s8_hit_r;
    out_distance <= s8_hit_r ? d8_r : '0;
    out_point_x  <= s8_hit_r ? pt[0] : '0;
    out_point_y  <= s8_hit_r ? pt[1] : '0;
    out_point_z  <= s8_hit_r ? pt[2] : '0;
  end
endmodule

// File: rtl/rti_checker.sv
// ----------------------------------------------------------------------------
// rti_checker
// Port-level checks for the ray triangle intersection block.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_macros.svh"
module rti_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_hit,
  input logic [31:0] out_distance,
  input logic [31:0] out_point_x,
  input logic        pready
);
  `RTI_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !out_hit, out_distance == 32'd0 && out_point_x == 32'd0, "miss with nonzero outputs")
  `RTI_ASSERT_IMP(a_hit_pos, clk, rst_n, out_valid && out_hit, !out_distance[31] && out_distance != 32'd0, "hit with nonpositive distance")
  `RTI_ASSERT_NEXT(a_never_busy, clk, rst_n, 1'b1, !busy && pready, "block stalled")
endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid), .out_hit(out_hit),
  .out_distance(out_distance), .out_point_x(out_point_x), .pready(pready)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point ray against triangle test.
// ----------------------------------------------------------------------------
// Triangle beats are queued by a stimulus process and sent by a clocked
// driver in random bursts. Every accepted beat is run through a local
// Moller-Trumbore predictor, which uses exact 192-bit arithmetic and the
// bench's own copy of the ray registers. The result is queued as the
// expected outcome. A clocked monitor compares every output strobe with the
// oldest expected outcome, field by field. Ray registers are rewritten over
// APB between phases, and only after the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rti_pkg::*;

  localparam int FRAC = 16;
  localparam int ONE = 65536;
  // The divider pipeline has one stage per quotient bit, plus the front
  // stages. This drain time covers it with some margin.
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic signed [31:0] c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z;
  } triangle_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] distance, px, py, pz;
  } hit_info_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  triangle_t tri_drv = '0;
  logic out_valid, out_hit;
  logic signed [31:0] out_distance, out_point_x, out_point_y, out_point_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #5 clk = ~clk;

  ray_triangle_intersect dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_corner0_x(tri_drv.c0x), .in_corner0_y(tri_drv.c0y), .in_corner0_z(tri_drv.c0z),
    .in_corner1_x(tri_drv.c1x), .in_corner1_y(tri_drv.c1y), .in_corner1_z(tri_drv.c1z),
    .in_corner2_x(tri_drv.c2x), .in_corner2_y(tri_drv.c2y), .in_corner2_z(tri_drv.c2z),
    .out_valid(out_valid), .out_hit(out_hit), .out_distance(out_distance),
    .out_point_x(out_point_x), .out_point_y(out_point_y), .out_point_z(out_point_z),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // The bench's copy of the ray registers, updated with every APB write.
  logic signed [31:0] ray_org [3];
  logic signed [31:0] ray_dir [3];
  logic [30:0] ray_eps;

  triangle_t pending_tris[$];
  hit_info_t expected_hits[$];
  int mismatches = 0;

  // Exact Moller-Trumbore with the determinant-scaled barycentric tests.
  function automatic hit_info_t trace_triangle(triangle_t t);
    logic signed [191:0] c0 [3], c1 [3], c2 [3];
    logic signed [191:0] e1 [3], e2 [3], s [3], d [3], h [3], q [3];
    logic signed [191:0] a, absa, un, vn, tn, thr, quo, epsw;
    logic signed [63:0] tpar, prod, sh;
    logic signed [64:0] sum;
    hit_info_t r;
    r = '0;
    c0[0] = t.c0x; c0[1] = t.c0y; c0[2] = t.c0z;
    c1[0] = t.c1x; c1[1] = t.c1y; c1[2] = t.c1z;
    c2[0] = t.c2x; c2[1] = t.c2y; c2[2] = t.c2z;
    for (int k = 0; k < 3; k++) begin
      e1[k] = c1[k] - c0[k];
      e2[k] = c2[k] - c0[k];
      s[k] = ray_org[k];
      s[k] = s[k] - c0[k];
      d[k] = ray_dir[k];
    end
    h[0] = d[1] * e2[2] - d[2] * e2[1];
    h[1] = d[2] * e2[0] - d[0] * e2[2];
    h[2] = d[0] * e2[1] - d[1] * e2[0];
    a = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    absa = (a < 0) ? -a : a;
    epsw = {161'd0, ray_eps};
    thr = epsw <<< (2 * FRAC);
    if (a == 0 || absa < thr) return r;
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    un = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (a < 0) begin
      un = -un;
      vn = -vn;
      tn = -tn;
    end
    if (un < 0 || un > absa || vn < 0 || un + vn > absa) return r;
    if (tn <= 0) return r;
    quo = (tn <<< FRAC) / absa;
    if (quo <= epsw) return r;
    tpar = (quo > 192'sd2147483647) ? 64'sd2147483647 : quo[63:0];
    r.hit = 1'b1;
    r.distance = tpar[31:0];
    for (int k = 0; k < 3; k++) begin
      prod = 64'(ray_dir[k]) * tpar;
      sh = prod >>> FRAC;  // floor toward minus infinity
      sum = 65'(ray_org[k]) + 65'(sh);
      if (sum > 65'sd2147483647) sum = 65'sd2147483647;
      if (sum < -65'sd2147483648) sum = -65'sd2147483648;
      case (k)
        0: r.px = sum[31:0];
        1: r.py = sum[31:0];
        default: r.pz = sum[31:0];
      endcase
    end
    return r;
  endfunction

  // Driver: bursts of random length separated by random gaps. Prediction
  // happens at the edge that accepts the beat.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      logic accepted;
      accepted = start && !busy;
      if (accepted) expected_hits.push_back(trace_triangle(tri_drv));
      if (start && !accepted) begin
        // Hold the beat until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_tris.size() > 0) begin
        tri_drv <= pending_tris.pop_front();
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
          gap_left = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: hit=%0b dist=%0d", out_hit,
                                       out_distance);
      end else begin
        hit_info_t e;
        e = expected_hits.pop_front();
        if (out_hit !== e.hit || out_distance !== e.distance || out_point_x !== e.px ||
            out_point_y !== e.py || out_point_z !== e.pz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0b d=%0d p=(%0d,%0d,%0d) got hit=%0b d=%0d p=(%0d,%0d,%0d)",
                     e.hit, e.distance, e.px, e.py, e.pz, out_hit, out_distance,
                     out_point_x, out_point_y, out_point_z);
        end
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegOriginX: ray_org[0] = val;
      RegOriginY: ray_org[1] = val;
      RegOriginZ: ray_org[2] = val;
      RegDirX:    ray_dir[0] = val;
      RegDirY:    ray_dir[1] = val;
      RegDirZ:    ray_dir[2] = val;
      default:    ray_eps = val[30:0];
    endcase
  endtask

  task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, logic [31:0] eps);
    reg_write(RegOriginX, ox);
    reg_write(RegOriginY, oy);
    reg_write(RegOriginZ, oz);
    reg_write(RegDirX, dx);
    reg_write(RegDirY, dy);
    reg_write(RegDirZ, dz);
    reg_write(RegEps, eps);
  endtask

  // Sender pauses until the pipeline has emptied; ray writes follow this.
  task automatic drain();
    while (pending_tris.size() > 0 || start || expected_hits.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] noise32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic triangle_t noise_tri();
    triangle_t t;
    t = {noise32(), noise32(), noise32(), noise32(), noise32(), noise32(), noise32(),
         noise32(), noise32()};
    return t;
  endfunction

  function automatic logic [31:0] jitter(logic signed [31:0] p, int span);
    return p + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // A triangle placed around a point on the ray, so that many beats hit.
  function automatic triangle_t aimed_tri();
    logic signed [63:0] k;
    logic signed [31:0] p [3];
    int span;
    triangle_t t;
    k = $urandom_range(0, 3) == 0 ? -64'($urandom_range(1, 8)) : 64'($urandom_range(0, 60));
    for (int i = 0; i < 3; i++) p[i] = 32'(64'(ray_org[i]) + 64'(ray_dir[i]) * k);
    span = $urandom_range(1, 4) * ONE + $urandom_range(0, ONE - 1);
    t.c0x = jitter(p[0], span); t.c0y = jitter(p[1], span); t.c0z = jitter(p[2], span);
    t.c1x = jitter(p[0], span); t.c1y = jitter(p[1], span); t.c1z = jitter(p[2], span);
    t.c2x = jitter(p[0], span); t.c2y = jitter(p[1], span); t.c2z = jitter(p[2], span);
    return t;
  endfunction

  function automatic triangle_t flat_tri(int x0, y0, x1, y1, x2, y2, z);
    triangle_t t;
    t = {32'(x0), 32'(y0), 32'(z), 32'(x1), 32'(y1), 32'(z), 32'(x2), 32'(y2), 32'(z)};
    return t;
  endfunction

  task automatic random_phase(int count, int aimed_pct);
    for (int i = 0; i < count; i++)
      pending_tris.push_back($urandom_range(0, 99) < aimed_pct ? aimed_tri() : noise_tri());
    drain();
  endtask

  function automatic logic [31:0] small_coord(int range);
    return $signed($urandom_range(0, 2 * range)) - range;
  endfunction

  task automatic random_ray(logic [31:0] eps);
    set_ray(small_coord(100 * ONE), small_coord(100 * ONE), small_coord(100 * ONE),
            small_coord(4 * ONE), small_coord(4 * ONE), small_coord(4 * ONE), eps);
  endtask

  initial begin
    // Reset values of the ray registers.
    ray_org[0] = 0; ray_org[1] = 0; ray_org[2] = 0;
    ray_dir[0] = 0; ray_dir[1] = 0; ray_dir[2] = ONE;
    ray_eps = 31'd1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats against the reset ray along +z.
    pending_tris.push_back('0);                                   // zero determinant
    pending_tris.push_back({9{32'h7FFF_FFFF}});
    pending_tris.push_back({9{32'h8000_0000}});
    pending_tris.push_back(flat_tri(-ONE, -ONE, 2*ONE, -ONE, -ONE, 2*ONE, 5*ONE));  // hit
    pending_tris.push_back(flat_tri(-ONE, -ONE, -ONE, 2*ONE, 2*ONE, -ONE, 5*ONE));  // mirrored winding
    pending_tris.push_back(flat_tri(-ONE, -ONE, 2*ONE, -ONE, -ONE, 2*ONE, -5*ONE)); // behind origin
    pending_tris.push_back(flat_tri(0, -ONE, 2*ONE, -ONE, 0, 2*ONE, 3*ONE));       // u on edge
    pending_tris.push_back(flat_tri(-ONE, 0, ONE, 0, -ONE, ONE, 3*ONE));           // on an edge line
    pending_tris.push_back(flat_tri(ONE, ONE, 3*ONE, ONE, ONE, 3*ONE, 2*ONE));     // outside
    pending_tris.push_back(flat_tri(-ONE, -ONE, 2*ONE, -ONE, -ONE, 2*ONE, 0));     // zero distance
    pending_tris.push_back(flat_tri(-ONE, -ONE, 2*ONE, -ONE, -ONE, 2*ONE, 1));     // tiny distance
    pending_tris.push_back(flat_tri(-ONE, -ONE, 2*ONE, -ONE, -ONE, 2*ONE, 2));
    pending_tris.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'(ONE), 32'(ONE),
                            32'sd0, 32'(2*ONE), 32'(2*ONE)});              // parallel plane
    pending_tris.push_back(flat_tri(-1, -1, 2, -1, -1, 2, 5*ONE));          // below threshold
    pending_tris.push_back(flat_tri(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF));                      // widest triangle
    drain();

    // A nearly flat direction pushes the distance into saturation.
    set_ray(0, 0, 0, 1, 32'hFFFF_FFFF, 1, 0);
    pending_tris.push_back(flat_tri(-ONE, -ONE, 2*ONE, -ONE, -ONE, 2*ONE, 1000*ONE));
    pending_tris.push_back(flat_tri(-2, -2, 4, -2, -2, 4, 1));
    pending_tris.push_back(flat_tri(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 7*ONE));
    drain();

    random_ray($urandom_range(0, 4));
    random_phase(250, 75);

    random_ray(0);
    random_phase(200, 80);

    // Extreme ray and the largest threshold.
    set_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            1, 32'h7FFF_FFFF);
    random_phase(60, 40);

    set_ray(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
    random_phase(60, 60);

    random_ray($urandom_range(0, 300));
    random_phase(330, 80);

    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
